/* hw/rtl/weighted_random_entry_selector_assert.svh */
// Assertion macros for the weighted random entry selector.
`ifndef WEIGHTED_RANDOM_ENTRY_SELECTOR_ASSERT_SVH
`define WEIGHTED_RANDOM_ENTRY_SELECTOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define WRES_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wres: same-cycle check failed");
// Next-cycle implication.
`define WRES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wres: next-cycle check failed");
`else
`define WRES_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define WRES_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/wres_pkg.sv */
// Shared types, constants and helpers of the weighted random entry selector.
`timescale 1ns / 1ps
package wres_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int WEIGHT_W     = 15;
    localparam int ID_W         = 16;
    localparam int DRAW_W       = 20;
    localparam int IDX_OUT_W    = 4;
    localparam int CNT_OUT_W    = 5;
    localparam int TOT_OUT_W    = 19;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NULL_ID  = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FALLBACK = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [WEIGHT_W-1:0] weight;
    } t_entry;

    // Controls of the shared add/compare unit.
    typedef struct packed {
        logic clear;      // zero the running sum
        logic update;     // take the adder output into the running sum
        logic use_total;  // add the new weight to the stored total instead
    } t_acc_ctl;

    typedef struct packed {
        t_status              status;
        logic [IDX_OUT_W-1:0] idx;
        logic [ID_W-1:0]      id;
        logic [CNT_OUT_W-1:0] count;
        logic [TOT_OUT_W-1:0] total;
    } t_result;

    // Raise a non-positive weight to 1.
    function automatic logic [WEIGHT_W-1:0] clamp_weight(input logic [15:0] w);
        logic [WEIGHT_W-1:0] r;
        if (w[15] || (w == 16'd0)) begin
            r = WEIGHT_W'(1);
        end else begin
            r = w[WEIGHT_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/weighted_random_entry_selector.sv */
// Top level of the weighted random entry selector (roulette-wheel selection).
//
//   port group  dir  tdata fields (low bit first)                  tuser
//   s_*         in   entry_id[15:0] weight[31:16] rand_draw[51:32]  mode
//   m_*         out  chosen_index[3:0] chosen_id[19:4]              status
//                    entry_count[24:20] weight_total[43:25]
//
// Appends and empty-table selects pass through dispatch and emit only; other
// selects also scan from entry zero up to the chosen position, or over every
// entry on a fallback, as the scan reads one entry a cycle via the shared adder.
// i_rst_n is synchronous, active low; it empties the table and zeros the total.
// Stalls: s_tready stays low until the result of the current beat has entered
// the output register, so a full output register holds up the next accept.
`timescale 1ns / 1ps
`include "weighted_random_entry_selector_assert.svh"
module weighted_random_entry_selector import wres_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // entry_id, weight, rand_draw, zero pad
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // chosen_index, chosen_id, entry_count,
                                   // weight_total, zero pad
    output logic [2:0]  m_tuser    // status
);

    localparam int IW  = $clog2(CAPACITY);
    localparam int CNW = $clog2(CAPACITY + 1);
    // Wide enough for CAPACITY full-scale weights.
    localparam int TW  = WEIGHT_W + $clog2(CAPACITY);

    logic                r_m_tvalid, n_m_tvalid;
    t_result             r_out, n_out;
    logic                out_free;
    logic                res_valid;
    t_result             res;
    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic [IW-1:0]       ram_raddr;
    t_entry              ram_wdata;
    t_entry              ram_rdata;
    t_acc_ctl            acc_ctl;
    logic [TW-1:0]       total;
    logic [TW-1:0]       sum;
    logic                hit;
    logic [WEIGHT_W-1:0] new_weight;
    logic [DRAW_W-1:0]   draw;

    // Output register frees up when empty or drained this cycle.
    assign out_free = !r_m_tvalid || m_tready;

    wres_ctrl #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .CNW      (CNW),
        .TW       (TW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_tvalid),
        .o_in_ready   (s_tready),
        .i_mode       (s_tuser),
        .i_id         (s_tdata[15:0]),
        .i_weight     (s_tdata[31:16]),
        .i_draw       (s_tdata[51:32]),
        .i_out_free   (out_free),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_we         (ram_we),
        .o_waddr      (ram_waddr),
        .o_wdata      (ram_wdata),
        .o_raddr      (ram_raddr),
        .i_rdata      (ram_rdata),
        .o_acc_ctl    (acc_ctl),
        .o_total      (total),
        .o_new_weight (new_weight),
        .o_draw       (draw),
        .i_sum        (sum),
        .i_hit        (hit)
    );

    // Entry table: id and clamped weight per slot, filled in order.
    wres_ram #(
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Shared unit: total update on append, running sum and compare on scan.
    wres_acc #(
        .TW (TW)
    ) u_acc (
        .i_clk        (i_clk),
        .i_ctl        (acc_ctl),
        .i_total      (total),
        .i_new_weight (new_weight),
        .i_ram_weight (ram_rdata.weight),
        .i_draw       (draw),
        .o_sum        (sum),
        .o_hit        (hit)
    );

    // Load a finished result, drop valid once the beat is taken.
    always_comb begin
        n_m_tvalid = r_m_tvalid;
        n_out      = r_out;
        if (res_valid && out_free) begin
            n_m_tvalid = 1'b1;
            n_out      = res;
        end else if (m_tready) begin
            n_m_tvalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else begin
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tuser  = r_out.status;
    assign m_tdata  = {4'b0000, r_out.total, r_out.count, r_out.id, r_out.idx};

    // One beat at a time: ready drops right after an accept.
    `WRES_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_tvalid && s_tready, !s_tready)
    // Rejected appends and empty selects carry no selection.
    `WRES_ASSERT_SAME(a_no_pick, i_clk, i_rst_n, m_tvalid && ((m_tuser == ST_NULL_ID) || (m_tuser == ST_FULL) || (m_tuser == ST_EMPTY)), m_tdata[19:0] == 20'd0)
    // An empty table has no weight.
    `WRES_ASSERT_SAME(a_empty_zero, i_clk, i_rst_n, m_tvalid && (m_tuser == ST_EMPTY), m_tdata[43:20] == 24'd0)

endmodule

/* hw/rtl/wres_ram.sv */
// Entry memory: one write port, one registered read port.
`timescale 1ns / 1ps
module wres_ram import wres_pkg::*; #(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int AW    = $clog2(CAPACITY_DEF)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/wres_acc.sv */
// Shared adder with running sum register and draw compare.
`timescale 1ns / 1ps
module wres_acc import wres_pkg::*; #(
    parameter int TW = WEIGHT_W + $clog2(CAPACITY_DEF)
) (
    input  logic                i_clk,
    input  t_acc_ctl            i_ctl,
    input  logic [TW-1:0]       i_total,
    input  logic [WEIGHT_W-1:0] i_new_weight,
    input  logic [WEIGHT_W-1:0] i_ram_weight,
    input  logic [DRAW_W-1:0]   i_draw,
    output logic [TW-1:0]       o_sum,
    output logic                o_hit
);

    localparam int CW = (TW > DRAW_W) ? TW : DRAW_W;

    logic [TW-1:0] r_acc;
    logic [TW-1:0] n_acc;
    logic [TW-1:0] op_a;
    logic [TW-1:0] op_b;

    always_comb begin
        op_a = i_ctl.use_total ? i_total : r_acc;
        op_b = i_ctl.use_total ? TW'(i_new_weight) : TW'(i_ram_weight);
        o_sum = op_a + op_b;
        o_hit = CW'(i_draw) < CW'(o_sum);
    end

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clear) begin
            n_acc = '0;
        end else if (i_ctl.update) begin
            n_acc = o_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

endmodule

/* hw/rtl/wres_ctrl.sv */
// Sequencer: append, scan of the cumulative weights, result hand-off.
`timescale 1ns / 1ps
module wres_ctrl import wres_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IW       = $clog2(CAPACITY_DEF),
    parameter int CNW      = $clog2(CAPACITY_DEF + 1),
    parameter int TW       = WEIGHT_W + $clog2(CAPACITY_DEF)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_mode,
    input  logic [ID_W-1:0]     i_id,
    input  logic [15:0]         i_weight,
    input  logic [DRAW_W-1:0]   i_draw,
    input  logic                i_out_free,
    output logic                o_res_valid,
    output t_result             o_res,
    output logic                o_we,
    output logic [IW-1:0]       o_waddr,
    output t_entry              o_wdata,
    output logic [IW-1:0]       o_raddr,
    input  t_entry              i_rdata,
    output t_acc_ctl            o_acc_ctl,
    output logic [TW-1:0]       o_total,
    output logic [WEIGHT_W-1:0] o_new_weight,
    output logic [DRAW_W-1:0]   o_draw,
    input  logic [TW-1:0]       i_sum,
    input  logic                i_hit
);

    t_state              r_state, n_state;
    logic [CNW-1:0]      r_count, n_count;
    logic [TW-1:0]       r_total, n_total;
    logic [IW-1:0]       r_idx, n_idx;
    logic                r_mode, n_mode;
    logic [ID_W-1:0]     r_id, n_id;
    logic [WEIGHT_W-1:0] r_weight, n_weight;
    logic [DRAW_W-1:0]   r_draw, n_draw;
    t_status             r_status, n_status;
    logic [IW-1:0]       r_cidx, n_cidx;
    logic [ID_W-1:0]     r_cid, n_cid;
    logic [ID_W-1:0]     r_id0, n_id0;

    logic [IW-1:0]        idx_inc;
    logic [CNW-1:0]       idx_cnt;
    logic                 last;
    logic                 full;
    logic [IW+IDX_OUT_W-1:0] cidx_ext;
    logic [CNW+CNT_OUT_W-1:0] cnt_ext;
    logic [TW+TOT_OUT_W-1:0]  tot_ext;

    assign idx_inc = r_idx + IW'(1);
    assign idx_cnt = CNW'(r_idx) + CNW'(1);
    assign last    = (idx_cnt == r_count);
    assign full    = (r_count == CNW'(CAPACITY));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (r_mode && (r_count != '0)) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SCAN: begin
                if (i_hit || last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and datapath updates.
    always_comb begin
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_we        = 1'b0;
        o_raddr     = r_idx;
        o_acc_ctl   = '0;
        n_count     = r_count;
        n_total     = r_total;
        n_idx       = r_idx;
        n_mode      = r_mode;
        n_id        = r_id;
        n_weight    = r_weight;
        n_draw      = r_draw;
        n_status    = r_status;
        n_cidx      = r_cidx;
        n_cid       = r_cid;
        n_id0       = r_id0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_mode   = i_mode;
                    n_id     = i_id;
                    n_weight = clamp_weight(i_weight);
                    n_draw   = i_draw;
                end
            end
            S_DISPATCH: begin
                n_cidx          = '0;
                n_cid           = '0;
                n_idx           = '0;
                o_raddr         = '0;
                o_acc_ctl.clear = 1'b1;
                if (!r_mode) begin
                    o_acc_ctl.use_total = 1'b1;
                    if (r_id == '0) begin
                        n_status = ST_NULL_ID;
                    end else if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status = ST_OK;
                        o_we     = 1'b1;
                        n_count  = r_count + CNW'(1);
                        n_total  = i_sum;
                    end
                end else if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end
            end
            S_SCAN: begin
                o_acc_ctl.update = 1'b1;
                if (r_idx == '0) begin
                    n_id0 = i_rdata.id;
                end
                if (i_hit) begin
                    n_status = ST_OK;
                    n_cidx   = r_idx;
                    n_cid    = i_rdata.id;
                end else if (last) begin
                    n_status = ST_FALLBACK;
                    n_cidx   = '0;
                    n_cid    = (r_idx == '0) ? i_rdata.id : r_id0;
                end else begin
                    n_idx   = idx_inc;
                    o_raddr = idx_inc;
                end
            end
            S_EMIT: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_mode   <= n_mode;
        r_id     <= n_id;
        r_weight <= n_weight;
        r_draw   <= n_draw;
        r_status <= n_status;
        r_cidx   <= n_cidx;
        r_cid    <= n_cid;
        r_id0    <= n_id0;
    end

    assign o_waddr        = r_count[IW-1:0];
    assign o_wdata.id     = r_id;
    assign o_wdata.weight = r_weight;
    assign o_total        = r_total;
    assign o_new_weight   = r_weight;
    assign o_draw         = r_draw;

    // Mask the wide internal values to the result field widths.
    assign cidx_ext = {{IDX_OUT_W{1'b0}}, r_cidx};
    assign cnt_ext  = {{CNT_OUT_W{1'b0}}, r_count};
    assign tot_ext  = {{TOT_OUT_W{1'b0}}, r_total};

    assign o_res.status = r_status;
    assign o_res.idx    = cidx_ext[IDX_OUT_W-1:0];
    assign o_res.id     = r_cid;
    assign o_res.count  = cnt_ext[CNT_OUT_W-1:0];
    assign o_res.total  = tot_ext[TOT_OUT_W-1:0];

endmodule

/* dv/tb_top.sv */
// Self-checking testbench of the weighted random entry selector.
`timescale 1ns / 1ps
module tb_top import wres_pkg::*;;

    localparam int  CAP          = CAPACITY_DEF;
    localparam int  NUM_RANDOM   = 1186;
    localparam int  WATCHDOG_MAX = 5000;
    localparam int  QUIET_LO     = 400;      // no idling on either side in this beat range
    localparam int  QUIET_HI     = 700;
    localparam int  DRAIN_A      = 200;      // sender holds here until all results are back
    localparam int  DRAIN_B      = 900;
    localparam int  TAIL_CYCLES  = 40;
    localparam int  MAX_REPORTS  = 40;
    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_PICK   = 1'b1;

    typedef struct {
        logic        mode;
        logic [15:0] entry_id;
        logic [15:0] weight;
        logic [19:0] draw;
    } t_request;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;   // entry_id, weight, rand_draw, zero pad
    logic        s_tuser  = 1'b0; // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // chosen_index, chosen_id, entry_count, weight_total, pad
    logic [2:0]  m_tuser;         // status

    t_request    pending_reqs[$];
    t_result     expected_picks[$];

    // Own copy of the entry table, updated as requests are accepted.
    logic [14:0] tbl_weight[CAP];
    logic [15:0] tbl_id[CAP];
    int          tbl_count = 0;
    int unsigned tbl_total = 0;

    // Stimulus-side view of the table, used to aim the draws and to pace the appends.
    int          gen_cnt = 0;
    int unsigned gen_tot = 0;
    int unsigned gen_edges[CAP];

    int          sent_cnt  = 0;
    int          got_cnt   = 0;
    int          err_cnt   = 0;
    int          stall_cnt = 0;
    logic        s_fire    = 1'b0;

    weighted_random_entry_selector u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Zero or negative weights are stored as 1.
    function automatic logic [14:0] eff_weight(input logic [15:0] wraw);
        return (wraw[15] || wraw == 16'd0) ? 15'd1 : wraw[14:0];
    endfunction

    // Apply one request to the table copy and return the result it must produce.
    function automatic t_result spin_wheel(input t_request req);
        t_result     r;
        int unsigned run_sum;
        logic        found;
        logic [14:0] w;
        r.status = ST_OK;
        r.idx    = '0;
        r.id     = '0;
        if (req.mode == MODE_ADD) begin
            if (req.entry_id == 16'd0) begin
                r.status = ST_NULL_ID;
            end else if (tbl_count >= CAP) begin
                r.status = ST_FULL;
            end else begin
                w = eff_weight(req.weight);
                tbl_weight[tbl_count] = w;
                tbl_id[tbl_count]     = req.entry_id;
                tbl_count++;
                tbl_total += w;
            end
        end else if (tbl_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            run_sum = 0;
            found   = 1'b0;
            for (int i = 0; i < tbl_count; i++) begin
                run_sum += tbl_weight[i];
                if (!found && req.draw < run_sum) begin
                    found  = 1'b1;
                    r.idx  = 4'(i);
                    r.id   = tbl_id[i];
                end
            end
            if (!found) begin
                r.status = ST_FALLBACK;
                r.id     = tbl_id[0];
            end
        end
        r.count = tbl_count[4:0];
        r.total = tbl_total[18:0];
        return r;
    endfunction

    function automatic void check_field(input string fld, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want, got);
        end
    endfunction

    task automatic queue_req(input logic mode, input logic [15:0] eid,
                             input logic [15:0] w, input logic [19:0] draw);
        t_request r;
        r.mode     = mode;
        r.entry_id = eid;
        r.weight   = w;
        r.draw     = draw;
        pending_reqs.push_back(r);
        if (mode == MODE_ADD && eid != 16'd0 && gen_cnt < CAP) begin
            gen_tot += eff_weight(w);
            gen_edges[gen_cnt] = gen_tot;
            gen_cnt++;
        end
    endtask

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'($urandom_range(1, 16));
            4, 5, 6:    return 16'($urandom_range(1, 32767));
            7:          return 16'h0000;
            8:          return {1'b1, 15'($urandom)};
            default:    return 16'($urandom);
        endcase
    endfunction

    // Mostly legal draws, some on or just below a cumulative boundary, some out of range.
    function automatic logic [19:0] rand_draw();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (gen_tot == 0 || k < 5)
            return 20'($urandom);
        if (k < 15)
            return 20'($urandom_range(gen_tot, 20'hFFFFF));
        if (k < 35)
            return 20'(gen_edges[$urandom_range(0, gen_cnt - 1)] - $urandom_range(0, 1));
        return 20'($urandom_range(0, gen_tot - 1));
    endfunction

    // Driver: present a new beat at the falling edge once the last one was taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_tvalid || s_fire)) begin
            if (pending_reqs.size() != 0
                && !((sent_cnt == DRAIN_A || sent_cnt == DRAIN_B) && expected_picks.size() != 0)
                && ((sent_cnt >= QUIET_LO && sent_cnt < QUIET_HI)
                    || $urandom_range(0, 99) >= 15)) begin
                s_tdata  <= {4'b0, pending_reqs[0].draw, pending_reqs[0].weight,
                             pending_reqs[0].entry_id};
                s_tuser  <= pending_reqs[0].mode;
                s_tvalid <= 1'b1;
                void'(pending_reqs.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver backpressure.
    always @(negedge i_clk) begin
        if (i_rst_n)
            m_tready <= (got_cnt >= QUIET_LO && got_cnt < QUIET_HI)
                        || $urandom_range(0, 99) >= 15;
    end

    // Monitor: predict on every accepted request, check every accepted result.
    always @(posedge i_clk) begin
        t_request req;
        t_result  want;
        logic     any_beat;
        any_beat = 1'b0;
        s_fire  <= i_rst_n && s_tvalid && s_tready;
        if (i_rst_n && s_tvalid && s_tready) begin
            req.mode     = s_tuser;
            req.entry_id = s_tdata[15:0];
            req.weight   = s_tdata[31:16];
            req.draw     = s_tdata[51:32];
            expected_picks.push_back(spin_wheel(req));
            sent_cnt <= sent_cnt + 1;
            any_beat = 1'b1;
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            any_beat = 1'b1;
            got_cnt <= got_cnt + 1;
            if (expected_picks.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual status %0d idx %0d",
                             $time, m_tuser, m_tdata[3:0]);
            end else begin
                want = expected_picks.pop_front();
                check_field("status",       want.status, m_tuser);
                check_field("chosen_index", want.idx,    m_tdata[3:0]);
                check_field("chosen_id",    want.id,     m_tdata[19:4]);
                check_field("entry_count",  want.count,  m_tdata[24:20]);
                check_field("weight_total", want.total,  m_tdata[43:25]);
            end
        end
        if (!i_rst_n || any_beat) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= WATCHDOG_MAX) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        bit full_seen;
        full_seen = 1'b0;

        // Directed: empty table, null id, weight extremes, boundary and out-of-range draws.
        queue_req(MODE_PICK, 16'h0000, 16'h0000, 20'd0);
        queue_req(MODE_PICK, 16'hFFFF, 16'h7FFF, 20'hFFFFF);
        queue_req(MODE_ADD,  16'h0000, 16'h0005, 20'hFFFFF);
        queue_req(MODE_ADD,  16'hFFFF, 16'h7FFF, 20'd0);
        queue_req(MODE_ADD,  16'h0001, 16'h0000, 20'd0);
        queue_req(MODE_ADD,  16'h1234, 16'hFFFF, 20'd0);
        queue_req(MODE_ADD,  16'h8000, 16'h8000, 20'd0);
        queue_req(MODE_ADD,  16'hABCD, 16'h0001, 20'd0);
        queue_req(MODE_PICK, 16'h0000, 16'h0000, 20'd0);
        queue_req(MODE_PICK, 16'h5555, 16'h8000, 20'd32766);
        queue_req(MODE_PICK, 16'h0000, 16'h0000, 20'd32767);
        queue_req(MODE_PICK, 16'h0000, 16'h0000, 20'd32770);
        queue_req(MODE_PICK, 16'h0000, 16'h0000, 20'd32771);
        queue_req(MODE_PICK, 16'h0000, 16'h0000, 20'hFFFFF);

        // Random: the table grows slowly so selects run at every size, then stays full.
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if ((gen_cnt < CAP && $urandom_range(0, 99) < 8)
                || (gen_cnt == CAP && $urandom_range(0, 99) < 5)) begin
                queue_req(MODE_ADD,
                          ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom),
                          rand_weight(), 20'($urandom));
            end else begin
                queue_req(MODE_PICK, 16'($urandom), 16'($urandom), rand_draw());
            end
            if (gen_cnt == CAP && !full_seen) begin
                full_seen = 1'b1;
                queue_req(MODE_ADD, 16'h0777, 16'h0010, 20'd0);
                queue_req(MODE_ADD, 16'h0000, 16'h0010, 20'd0);
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_reqs.size() == 0);
        wait (!s_tvalid);
        wait (expected_picks.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
